FILE: rtl/chained_hash_table_engine_macros.svh
// ----------------------------------------------------------------------------
// Chained hash table engine: assertion macros
// Shared assertion helpers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_ENGINE_MACROS_SVH
`define CHAINED_HASH_TABLE_ENGINE_MACROS_SVH

`ifndef ASSERT_OFF
// plain property, checked every clock out of reset
`define CHTE_ASSERT(lbl, prop) \
lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
   else $error("chte: assertion failed");
// same-cycle implication
`define CHTE_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error("chte: implication failed");
// next-cycle implication
`define CHTE_ASSERT_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error("chte: next-cycle implication failed");
`else
`define CHTE_ASSERT(lbl, prop)
`define CHTE_ASSERT_IMP(lbl, ante, cons)
`define CHTE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/chte_pkg.sv
// ----------------------------------------------------------------------------
// Chained hash table engine: package
// Request/response types, status and op codes, sequencer states, defaults.
// ----------------------------------------------------------------------------
package chte_pkg;

   localparam int BUCKETS_DEFAULT    = 256;
   localparam int POOL_NODES_DEFAULT = 256;

   localparam int          CSR_AW             = 3;
   localparam logic [CSR_AW-1:0] CSR_BUCKET_COUNT = 3'd0;
   localparam logic [8:0]  BUCKET_COUNT_RESET = 9'd256;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_REMOVE = 2'd2,
      OP_UNDEF  = 2'd3
   } chte_op_type;

   typedef enum logic [2:0] {
      ST_NEW       = 3'd0,
      ST_REPLACED  = 3'd1,
      ST_FOUND     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_REMOVED   = 3'd4,
      ST_FULL      = 3'd5
   } chte_status_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DIV,
      S_HEAD,
      S_HEAD_WAIT,
      S_NODE,
      S_CHECK,
      S_DECIDE,
      S_FREE_WAIT,
      S_LINK_PREV,
      S_UNLINK,
      S_RELEASE,
      S_RESP
   } chte_state_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] key;
      logic [31:0] value;
   } chte_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] result_value;
      logic [8:0]  entry_count;
   } chte_rsp_type;

endpackage

FILE: rtl/chained_hash_table_engine.sv
// ----------------------------------------------------------------------------
// Chained hash table engine
// Separate-chaining hash table on 32-bit keys with a fixed node pool.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_stall  | req_data  (op, key, value)
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_data  (status, value, count)
//  csr     | in/out    | psel/penable/pready    | paddr, pwdata, prdata
//
// A request steps from accept to the next accept through idle, the bit-serial
// key modulo, the bucket head read, the chain walk over the nodes visited in the
// node memories (registered read data), decide and write back, and the load
// of the response register.
// After reset the block clears the bucket heads and threads the free list;
// req_stall is high meanwhile.
// A finished response waits in the output register while rsp_stall is high.
// ----------------------------------------------------------------------------
`include "chained_hash_table_engine_macros.svh"

module chained_hash_table_engine
   import chte_pkg::*;
#(
   parameter int BUCKETS    = BUCKETS_DEFAULT,
   parameter int POOL_NODES = POOL_NODES_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  chte_req_type       req_data,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output chte_rsp_type       rsp_data,
   // register port
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [CSR_AW-1:0]  paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int NW       = $clog2(POOL_NODES + 1);
   localparam int NAW      = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
   localparam int HAW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int BW       = $clog2(BUCKETS + 1);
   localparam int INIT_LEN = (BUCKETS > POOL_NODES) ? BUCKETS : POOL_NODES;
   localparam int IW       = (INIT_LEN > 1) ? $clog2(INIT_LEN) : 1;
   localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

   // memories
   logic [NW-1:0] head_mem [BUCKETS];
   logic [63:0]   kv_mem   [POOL_NODES];
   logic [NW-1:0] next_mem [POOL_NODES];

   logic [NW-1:0]  head_rdata_ff;
   logic [63:0]    kv_rdata_ff;
   logic [NW-1:0]  next_rdata_ff;

   logic           head_we, kv_we, next_we;
   logic [HAW-1:0] head_addr;
   logic [NAW-1:0] kv_addr, next_addr;
   logic [NW-1:0]  head_wdata, next_wdata;
   logic [63:0]    kv_wdata;

   // control and datapath registers
   chte_state_type state_ff, state_in;
   logic [IW-1:0]  init_cnt_ff, init_cnt_in;
   logic [8:0]     bucket_count_ff;
   logic [1:0]     op_ff, op_in;
   logic [31:0]    key_ff, key_in;
   logic [31:0]    val_ff, val_in;
   logic [BW-1:0]  divisor_ff, divisor_in;
   logic [31:0]    dividend_ff, dividend_in;
   logic [BW-1:0]  rem_ff, rem_in;
   logic [4:0]     bit_cnt_ff, bit_cnt_in;
   logic [NW-1:0]  cur_ff, cur_in;
   logic [NW-1:0]  prev_ff, prev_in;
   logic [31:0]    cur_val_ff, cur_val_in;
   logic [NW-1:0]  cur_next_ff, cur_next_in;
   logic [NW-1:0]  free_head_ff, free_head_in;
   logic [NW-1:0]  live_count_ff, live_count_in;
   logic [2:0]     status_ff, status_in;
   logic [31:0]    rv_ff, rv_in;
   logic           rsp_valid_ff, rsp_valid_in;
   chte_rsp_type   rsp_ff, rsp_in;

   logic           cur_ok, prev_ok, free_ok, next_ok, head_ok, key_hit;
   logic           rsp_free;
   logic [BW:0]    div_shift;
   logic [BW-1:0]  active_n;

   assign cur_ok   = cur_ff < NIL;
   assign prev_ok  = prev_ff < NIL;
   assign free_ok  = free_head_ff < NIL;
   assign next_ok  = next_rdata_ff < NIL;
   assign head_ok  = head_rdata_ff < NIL;
   assign key_hit  = kv_rdata_ff[63:32] == key_ff;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // bucket count clamped to 1..BUCKETS
   always_comb begin
      if (bucket_count_ff == 9'd0) begin
         active_n = BW'(1);
      end else if (32'(bucket_count_ff) > 32'(BUCKETS)) begin
         active_n = BW'(BUCKETS);
      end else begin
         active_n = BW'(bucket_count_ff);
      end
   end

   // one restoring-division step
   assign div_shift = {rem_ff, dividend_ff[31]};

   // register port
   assign pready = 1'b1;
   assign prdata = (paddr == CSR_BUCKET_COUNT) ? {23'd0, bucket_count_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= BUCKET_COUNT_RESET;
      end else if (psel && penable && pwrite && pready && paddr == CSR_BUCKET_COUNT) begin
         bucket_count_ff <= pwdata[8:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            if (init_cnt_ff == IW'(INIT_LEN - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_DIV;
         end
         S_DIV: begin
            if (bit_cnt_ff == 5'd31) state_in = S_HEAD;
         end
         S_HEAD:      state_in = S_HEAD_WAIT;
         S_HEAD_WAIT: state_in = head_ok ? S_NODE : S_DECIDE;
         S_NODE:      state_in = S_CHECK;
         S_CHECK: begin
            if (key_hit || !next_ok) state_in = S_DECIDE;
            else state_in = S_NODE;
         end
         S_DECIDE: begin
            if (op_ff == OP_INSERT && !cur_ok && free_ok) state_in = S_FREE_WAIT;
            else if (op_ff == OP_REMOVE && cur_ok) state_in = S_UNLINK;
            else state_in = S_RESP;
         end
         S_FREE_WAIT: state_in = prev_ok ? S_LINK_PREV : S_RESP;
         S_LINK_PREV: state_in = S_RESP;
         S_UNLINK:    state_in = S_RELEASE;
         S_RELEASE:   state_in = S_RESP;
         S_RESP: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default:     state_in = S_INIT;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      init_cnt_in   = init_cnt_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      divisor_in    = divisor_ff;
      dividend_in   = dividend_ff;
      rem_in        = rem_ff;
      bit_cnt_in    = bit_cnt_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      cur_val_in    = cur_val_ff;
      cur_next_in   = cur_next_ff;
      free_head_in  = free_head_ff;
      live_count_in = live_count_ff;
      status_in     = status_ff;
      rv_in         = rv_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      req_stall     = state_ff != S_IDLE;
      head_we       = 1'b0;
      kv_we         = 1'b0;
      next_we       = 1'b0;
      head_addr     = rem_ff[HAW-1:0];
      kv_addr       = cur_ff[NAW-1:0];
      next_addr     = cur_ff[NAW-1:0];
      head_wdata    = NIL;
      next_wdata    = NIL;
      kv_wdata      = {key_ff, val_ff};
      case (state_ff)
         // clear bucket heads, thread the free list
         S_INIT: begin
            head_addr   = HAW'(init_cnt_ff);
            next_addr   = NAW'(init_cnt_ff);
            head_we     = 32'(init_cnt_ff) < 32'(BUCKETS);
            next_we     = 32'(init_cnt_ff) < 32'(POOL_NODES);
            next_wdata  = NW'(init_cnt_ff) + NW'(1);
            init_cnt_in = init_cnt_ff + IW'(1);
         end
         S_IDLE: begin
            op_in       = req_data.op;
            key_in      = req_data.key;
            val_in      = req_data.value;
            dividend_in = req_data.key;
            divisor_in  = active_n;
            rem_in      = '0;
            bit_cnt_in  = 5'd0;
            rv_in       = 32'd0;
         end
         S_DIV: begin
            if (div_shift >= {1'b0, divisor_ff}) begin
               rem_in = BW'(div_shift - {1'b0, divisor_ff});
            end else begin
               rem_in = BW'(div_shift);
            end
            dividend_in = {dividend_ff[30:0], 1'b0};
            bit_cnt_in  = bit_cnt_ff + 5'd1;
         end
         S_HEAD: begin
            head_addr = rem_ff[HAW-1:0];
         end
         S_HEAD_WAIT: begin
            cur_in  = head_rdata_ff;
            prev_in = NIL;
         end
         S_NODE: begin
            kv_addr   = cur_ff[NAW-1:0];
            next_addr = cur_ff[NAW-1:0];
         end
         // compare key, step along the chain on a miss
         S_CHECK: begin
            if (key_hit) begin
               cur_val_in  = kv_rdata_ff[31:0];
               cur_next_in = next_rdata_ff;
            end else begin
               prev_in = cur_ff;
               cur_in  = next_rdata_ff;
            end
         end
         S_DECIDE: begin
            case (op_ff)
               OP_INSERT: begin
                  if (cur_ok) begin
                     kv_addr   = cur_ff[NAW-1:0];
                     kv_we     = 1'b1;
                     rv_in     = cur_val_ff;
                     status_in = ST_REPLACED;
                  end else if (!free_ok) begin
                     status_in = ST_FULL;
                  end else begin
                     next_addr = free_head_ff[NAW-1:0];
                  end
               end
               OP_REMOVE: begin
                  if (!cur_ok) status_in = ST_NOT_FOUND;
               end
               default: begin
                  if (cur_ok) begin
                     rv_in     = cur_val_ff;
                     status_in = ST_FOUND;
                  end else begin
                     status_in = ST_NOT_FOUND;
                  end
               end
            endcase
         end
         // new node from the free list
         S_FREE_WAIT: begin
            kv_addr       = free_head_ff[NAW-1:0];
            kv_we         = 1'b1;
            next_addr     = free_head_ff[NAW-1:0];
            next_we       = 1'b1;
            next_wdata    = NIL;
            head_we       = !prev_ok;
            head_wdata    = free_head_ff;
            cur_in        = free_head_ff;
            free_head_in  = next_rdata_ff;
            live_count_in = live_count_ff + NW'(1);
            status_in     = ST_NEW;
         end
         S_LINK_PREV: begin
            next_addr  = prev_ff[NAW-1:0];
            next_we    = 1'b1;
            next_wdata = cur_ff;
         end
         S_UNLINK: begin
            next_addr  = prev_ff[NAW-1:0];
            next_we    = prev_ok;
            next_wdata = cur_next_ff;
            head_we    = !prev_ok;
            head_wdata = cur_next_ff;
            rv_in      = cur_val_ff;
            status_in  = ST_REMOVED;
            if (live_count_ff != '0) live_count_in = live_count_ff - NW'(1);
         end
         // removed node goes to the head of the free list
         S_RELEASE: begin
            next_addr    = cur_ff[NAW-1:0];
            next_we      = 1'b1;
            next_wdata   = free_head_ff;
            free_head_in = cur_ff;
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_in.status       = status_ff;
               rsp_in.result_value = rv_ff;
               rsp_in.entry_count  = 9'(live_count_ff);
               rsp_valid_in        = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // memories: read-first, registered read data
   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_addr] <= head_wdata;
      head_rdata_ff <= head_mem[head_addr];
   end

   always_ff @(posedge clock) begin
      if (kv_we) kv_mem[kv_addr] <= kv_wdata;
      kv_rdata_ff <= kv_mem[kv_addr];
   end

   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_addr] <= next_wdata;
      next_rdata_ff <= next_mem[next_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         init_cnt_ff   <= '0;
         free_head_ff  <= '0;
         live_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_cnt_ff   <= init_cnt_in;
         free_head_ff  <= free_head_in;
         live_count_ff <= live_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      divisor_ff  <= divisor_in;
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      bit_cnt_ff  <= bit_cnt_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      cur_val_ff  <= cur_val_in;
      cur_next_ff <= cur_next_in;
      status_ff   <= status_in;
      rv_ff       <= rv_in;
      rsp_ff      <= rsp_in;
   end

   // checks
   `CHTE_ASSERT(a_live_bound, live_count_ff <= NIL)
   `CHTE_ASSERT_IMP(a_free_avail, (state_ff == S_IDLE) && (live_count_ff < NIL), free_ok)
   `CHTE_ASSERT_NXT(a_accept_div, req_valid && !req_stall, state_ff == S_DIV)
   `CHTE_ASSERT_IMP(a_idle_quiet, state_ff == S_IDLE, !kv_we && !next_we && !head_we)

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chained hash table engine testbench
// Drives insert, lookup and remove requests through the valid/stall channel,
// predicts every response with a local copy of the bucket chains and the free
// list, and compares each response field by field. Bucket count is changed
// between phases over the register port, including out-of-range settings.
// Random gaps are applied on the request channel, random stalls on the response.
// ----------------------------------------------------------------------------
module tb;
   import chte_pkg::*;

   localparam int NIL = POOL_NODES_DEFAULT;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic         req_valid = 1'b0;
   logic         req_stall;
   chte_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b1;
   chte_rsp_type rsp_data;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   chained_hash_table_engine uut (.*);

   always #6 clock = ~clock;

   // shadow table
   int unsigned bucket_cfg;
   int unsigned head_tbl [BUCKETS_DEFAULT];
   int unsigned nkey [POOL_NODES_DEFAULT];
   int unsigned nval [POOL_NODES_DEFAULT];
   int unsigned nnext [POOL_NODES_DEFAULT];
   int unsigned free_idx;
   int unsigned live;

   chte_req_type pending_reqs [$];
   chte_rsp_type expected_rsps [$];
   logic [31:0]  known_keys [$];
   int           err_count = 0;
   int           rsp_count = 0;
   int           full_hits = 0;
   int           req_gap = 0;
   bit           quiet = 0;
   logic         req_taken = 1'b0;

   // compute one response and update the shadow table
   function automatic chte_rsp_type hash_table_apply(chte_req_type rq);
      chte_rsp_type r;
      int unsigned nb, b, prev, cur, steps, n;
      nb = (bucket_cfg == 0) ? 1 : (bucket_cfg > BUCKETS_DEFAULT) ? BUCKETS_DEFAULT
                                                                 : bucket_cfg;
      b = rq.key % nb;
      prev = NIL;
      cur = head_tbl[b];
      steps = 0;
      r = '0;
      while (cur < NIL && steps < NIL && nkey[cur] != rq.key) begin
         prev = cur;
         cur = nnext[cur];
         steps++;
      end
      if (cur >= NIL || nkey[cur] != rq.key) cur = NIL;
      case (chte_op_type'(rq.op))
         OP_INSERT: begin
            if (cur < NIL) begin
               r.result_value = nval[cur];
               nval[cur] = rq.value;
               r.status = ST_REPLACED;
            end else if (free_idx >= NIL) begin
               r.status = ST_FULL;
            end else begin
               n = free_idx;
               free_idx = nnext[n];
               nkey[n] = rq.key;
               nval[n] = rq.value;
               nnext[n] = NIL;
               if (prev < NIL) nnext[prev] = n;
               else head_tbl[b] = n;
               live++;
               r.status = ST_NEW;
            end
         end
         OP_REMOVE: begin
            if (cur < NIL) begin
               r.result_value = nval[cur];
               if (prev < NIL) nnext[prev] = nnext[cur];
               else head_tbl[b] = nnext[cur];
               nnext[cur] = free_idx;
               free_idx = cur;
               if (live > 0) live--;
               r.status = ST_REMOVED;
            end else begin
               r.status = ST_NOT_FOUND;
            end
         end
         default: begin
            if (cur < NIL) begin
               r.result_value = nval[cur];
               r.status = ST_FOUND;
            end else begin
               r.status = ST_NOT_FOUND;
            end
         end
      endcase
      r.entry_count = live[8:0];
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
      err_count++;
   endtask

   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // request driver
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_gap = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b1;
      else rsp_stall <= (pick_gap() != 0);
   end

   // monitor: predict on request accept, check on response accept
   always @(posedge clock) begin
      chte_rsp_type want;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(hash_table_apply(req_data));
         end
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("pending responses", 32'd1, 32'd0);
            end else begin
               want = expected_rsps.pop_front();
               if (want.status == ST_FULL) full_hits++;
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 32'(want.status), 32'(rsp_data.status));
               if (rsp_data.result_value !== want.result_value)
                  report_mismatch("result_value", want.result_value, rsp_data.result_value);
               if (rsp_data.entry_count !== want.entry_count)
                  report_mismatch("entry_count", 32'(want.entry_count),
                                  32'(rsp_data.entry_count));
            end
         end
      end
   end

   task automatic write_bucket_count(logic [8:0] count);
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= CSR_BUCKET_COUNT;
      pwdata <= {23'd0, count};
      @(negedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      bucket_cfg = count;
   endtask

   task automatic push_req(chte_op_type op, logic [31:0] key, logic [31:0] value);
      chte_req_type rq;
      rq.op = op;
      rq.key = key;
      rq.value = value;
      pending_reqs.push_back(rq);
   endtask

   // random mix; most keys come from the known set so chains get hits
   task automatic push_random(int n);
      int r;
      logic [31:0] k;
      chte_op_type op;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         op = (r < 45) ? OP_INSERT : (r < 70) ? OP_LOOKUP : (r < 95) ? OP_REMOVE : OP_UNDEF;
         if (known_keys.size() > 0 && $urandom_range(0, 9) < 8)
            k = known_keys[$urandom_range(0, known_keys.size() - 1)];
         else
            k = $urandom;
         push_req(op, k, $urandom);
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (8) @(posedge clock);
      quiet = ($urandom_range(0, 3) == 0);
   endtask

   initial begin
      bucket_cfg = BUCKET_COUNT_RESET;
      for (int i = 0; i < BUCKETS_DEFAULT; i++) head_tbl[i] = NIL;
      for (int i = 0; i < POOL_NODES_DEFAULT; i++) begin
         nkey[i] = 0;
         nval[i] = 0;
         nnext[i] = i + 1;
      end
      free_idx = 0;
      live = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, collisions, removes at head/middle/tail
      push_req(OP_LOOKUP, 32'h0, 32'hFFFF_FFFF);
      push_req(OP_INSERT, 32'h0, 32'h0);
      push_req(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_req(OP_INSERT, 32'hFFFF_FFFF, 32'h1234_5678);
      push_req(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
      push_req(OP_UNDEF, 32'h0, 32'hFFFF_FFFF);
      push_req(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
      push_req(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
      push_req(OP_INSERT, 32'h100, 32'hA5A5_A5A5);
      push_req(OP_INSERT, 32'h200, 32'h5A5A_5A5A);
      push_req(OP_INSERT, 32'h300, 32'h0000_0003);
      push_req(OP_LOOKUP, 32'h300, 32'h0);
      push_req(OP_REMOVE, 32'h100, 32'h0);
      push_req(OP_LOOKUP, 32'h200, 32'h0);
      push_req(OP_REMOVE, 32'h0, 32'h0);
      push_req(OP_REMOVE, 32'h300, 32'h0);
      push_req(OP_REMOVE, 32'h200, 32'h0);
      push_req(OP_INSERT, 32'h8000_0001, 32'h8000_0000);
      push_req(OP_REMOVE, 32'h8000_0001, 32'h0);
      push_req(OP_LOOKUP, 32'h8000_0001, 32'h0);
      push_req(OP_UNDEF, 32'h1234_5678, 32'h0);
      wait_drained();

      for (int i = 0; i < 48; i++) known_keys.push_back($urandom);

      // single bucket: every key on one chain
      write_bucket_count(9'd1);
      push_random(150);
      wait_drained();

      // odd count, existing chains now partly misplaced
      write_bucket_count(9'd7);
      push_random(200);
      wait_drained();

      // zero is treated as one bucket
      write_bucket_count(9'd0);
      push_random(100);
      wait_drained();

      // above range clamps to full size; fill the pool until inserts fail
      write_bucket_count(9'd511);
      for (int i = 0; i < 280; i++) begin
         known_keys.push_back(($urandom << 9) | i);
         push_req(OP_INSERT, known_keys[known_keys.size() - 1], $urandom);
      end
      push_random(150);
      wait_drained();

      // long chain walks after the pool fill
      write_bucket_count(9'd1);
      push_random(60);
      wait_drained();

      write_bucket_count(9'd256);
      push_random(100);
      wait_drained();

      repeat (50) @(posedge clock);
      $display("Checked %0d responses over bucket counts 256, 1, 7, 0, 511; %0d pool-full",
               rsp_count, full_hits);
      if (err_count == 0 && expected_rsps.size() == 0)
         $display("chained_hash_table_engine test passed");
      else
         $display("chained_hash_table_engine test failed");
      $finish;
   end

   initial begin
      #(12.0 * 4_000_000);
      $display("Timeout with %0d responses outstanding", expected_rsps.size());
      $display("chained_hash_table_engine test failed");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/chte_pkg.sv
rtl/chained_hash_table_engine.sv
dv/tb.sv
